FILE: src/bbpa_pkg.sv
// Shared types and constants of the bucket pool allocator.
package bbpa_pkg;

    localparam int MAP_BITS    = 32;
    localparam int MAX_BUCKETS = 32;
    localparam int MNG_MAX     = (MAX_BUCKETS < MAP_BITS) ? MAX_BUCKETS : MAP_BITS;
    localparam int IDX_W       = $clog2(MAP_BITS);
    localparam int CNT_W       = $clog2(MAP_BITS + 1);
    localparam int SIZE_W      = 20;
    localparam int NEED_W      = 18;
    localparam int REF_W       = 8;
    localparam int LOG2_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [SIZE_W-1:0] HDR_BYTES = 20'd4;
    localparam logic [LOG2_W-1:0] MIN_LOG2  = 4'd3;
    localparam logic [REF_W-1:0]  REF_MAX   = 8'd255;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_GET   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_RUN   = 2'd1,
        ST_BAD_HDL  = 2'd2,
        ST_REF_SAT  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKETS_IN_USE   = 1'b0,
        CFG_BUCKET_SIZE_LOG2 = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_PREP = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // status of the first-fit scanner toward the sequencer
    typedef struct packed {
        logic                done;
        logic                found;
        logic [IDX_W-1:0]    index;
        logic [MAP_BITS-1:0] mask;
    } t_fit_stat;

endpackage

FILE: src/bbpa_ifs.sv
// Valid/ready channel interfaces: request, response and configuration write.
interface bbpa_req_if import bbpa_pkg::*; ();
    logic              valid;
    logic              ready;
    t_action           action;
    logic [SIZE_W-1:0] request_size;
    logic [IDX_W-1:0]  handle_index;

    modport source (output valid, action, request_size, handle_index, input ready);
    modport sink   (input valid, action, request_size, handle_index, output ready);
endinterface

interface bbpa_rsp_if import bbpa_pkg::*; ();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [IDX_W-1:0]  bucket_index;
    logic [SIZE_W-1:0] payload_offset;

    modport source (output valid, status, bucket_index, payload_offset, input ready);
    modport sink   (input valid, status, bucket_index, payload_offset, output ready);
endinterface

interface bbpa_cfg_if import bbpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bbpa_fit.sv
// First-fit scanner: tests one start position per cycle with a sliding run mask.
module bbpa_fit import bbpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CNT_W-1:0]    i_need,
    input  logic [IDX_W-1:0]    i_limit,
    input  logic [MAP_BITS-1:0] i_map,
    output t_fit_stat           o_stat
);

    logic                r_busy;
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_lim;
    logic [MAP_BITS-1:0] r_mask;
    logic                w_hit;
    logic                w_last;

    assign w_hit  = (i_map & r_mask) == '0;
    assign w_last = r_pos == r_lim;

    always_comb begin
        o_stat.done  = r_busy && (w_hit || w_last);
        o_stat.found = r_busy && w_hit;
        o_stat.index = r_pos;
        o_stat.mask  = r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_stat.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pos  <= '0;
            r_lim  <= i_limit;
            r_mask <= MAP_BITS'(((MAP_BITS+1)'(1) << i_need) - (MAP_BITS+1)'(1));
        end else if (r_busy) begin
            r_pos  <= r_pos + IDX_W'(1);
            r_mask <= r_mask << 1;
        end
    end

endmodule

FILE: src/bitmap_bucket_pool_allocator_top.sv
// Bucket pool allocator: 32-bucket occupancy map with first-fit contiguous runs.
//
// Channels: i_req carries action, request_size and handle_index; o_rsp returns
// status, bucket_index and payload_offset, one beat per request beat. i_cfg
// writes buckets_in_use (index 0) and bucket_size_log2 (index 1); it is always
// ready. The user must see that it is written only while no request is in
// flight; the block does not enforce this. Free, get and clear go from idle
// through exec to done; alloc adds prep and scan, where the first-fit scanner
// tests k (1 to 32) start positions, one per cycle; a request too large for
// the pool skips the scan and goes from prep to done. i_req.ready is high only
// while the sequencer is idle, so one request is in flight at a time. The
// response sits in an output register, so a new request can be taken while a
// response waits; that request then holds in its last step until the output
// register is free.
// Reset (synchronous, active low) empties the map, zeroes all reference counts
// and restores 32 buckets of 64 bytes. No clearing pass is needed.
module bitmap_bucket_pool_allocator_top import bbpa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bbpa_req_if.sink   i_req,
    bbpa_rsp_if.source o_rsp,
    bbpa_cfg_if.sink   i_cfg
);

    t_state               r_state;
    t_state               n_state;

    logic [CFG_DATA_W-1:0] r_buckets;
    logic [LOG2_W-1:0]     r_log2;

    logic [MAP_BITS-1:0]  r_map;
    logic [REF_W-1:0]     r_ref [MAP_BITS];
    logic [CNT_W-1:0]     r_run [MAP_BITS];

    t_action              r_act;
    logic [SIZE_W-1:0]    r_size;
    logic [IDX_W-1:0]     r_hdl;
    logic [NEED_W-1:0]    r_need;

    t_status              r_res_status;
    logic [IDX_W-1:0]     r_res_idx;
    logic [SIZE_W-1:0]    r_res_off;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [IDX_W-1:0]     r_out_idx;
    logic [SIZE_W-1:0]    r_out_off;

    logic [LOG2_W-1:0]    w_sh;
    logic [CNT_W-1:0]     w_n;
    logic [SIZE_W-1:0]    w_bsz;
    logic [SIZE_W-1:0]    w_room;
    logic [SIZE_W-1:0]    w_rest;
    logic [NEED_W-1:0]    w_need;
    logic                 w_too_big;
    logic                 w_fit_start;
    logic [IDX_W-1:0]     w_limit;
    logic [REF_W-1:0]     w_rc;
    logic [MAP_BITS-1:0]  w_rel_mask;
    logic                 w_out_free;
    logic                 w_req_acc;
    t_fit_stat            w_fit;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= CFG_DATA_W'(MAP_BITS);
            r_log2    <= LOG2_W'(6);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_BUCKETS_IN_USE:   r_buckets <= i_cfg.data;
                CFG_BUCKET_SIZE_LOG2: r_log2    <= i_cfg.data[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_sh = (r_log2 < MIN_LOG2) ? MIN_LOG2 : r_log2;
    assign w_n  = (r_buckets > CFG_DATA_W'(MNG_MAX)) ? CNT_W'(MNG_MAX)
                                                     : CNT_W'(r_buckets);

    // ---------------- run sizing ----------------
    assign w_bsz  = SIZE_W'(1) << w_sh;
    assign w_room = w_bsz - HDR_BYTES;
    assign w_rest = r_size - w_room;

    always_comb begin
        if (r_size > w_room) begin
            w_need = NEED_W'(1) + NEED_W'(w_rest >> w_sh)
                   + NEED_W'(|(w_rest & (w_bsz - SIZE_W'(1))));
        end else begin
            w_need = NEED_W'(1);
        end
    end

    assign w_too_big   = r_need > NEED_W'(w_n);
    assign w_fit_start = (r_state == S_PREP) && !w_too_big;
    assign w_limit     = IDX_W'(w_n - r_need[CNT_W-1:0]);

    bbpa_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fit_start),
        .i_need  (r_need[CNT_W-1:0]),
        .i_limit (w_limit),
        .i_map   (r_map),
        .o_stat  (w_fit)
    );

    // ---------------- handle lookup ----------------
    assign w_rc       = r_ref[r_hdl];
    assign w_rel_mask = MAP_BITS'(
        (2*MAP_BITS)'(((MAP_BITS+1)'(1) << r_run[r_hdl]) - (MAP_BITS+1)'(1)) << r_hdl);

    // ---------------- sequencer ----------------
    assign i_req.ready = r_state == S_IDLE;
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_req_acc) n_state = S_EXEC;
            S_EXEC: n_state = (r_act == ACT_ALLOC) ? S_PREP : S_DONE;
            S_PREP: n_state = w_too_big ? S_DONE : S_SCAN;
            S_SCAN: if (w_fit.done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request latch and result staging
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_act  <= i_req.action;
            r_size <= i_req.request_size;
            r_hdl  <= i_req.handle_index;
        end
        case (r_state)
            S_EXEC: begin
                r_need    <= w_need;
                r_res_idx <= '0;
                r_res_off <= '0;
                case (r_act)
                    ACT_FREE: r_res_status <= (w_rc == '0) ? ST_BAD_HDL : ST_DONE;
                    ACT_GET: begin
                        if (w_rc == '0) begin
                            r_res_status <= ST_BAD_HDL;
                        end else if (w_rc == REF_MAX) begin
                            r_res_status <= ST_REF_SAT;
                        end else begin
                            r_res_status <= ST_DONE;
                        end
                    end
                    default: r_res_status <= ST_DONE;
                endcase
            end
            S_PREP: if (w_too_big) r_res_status <= ST_NO_RUN;
            S_SCAN: begin
                if (w_fit.done) begin
                    if (w_fit.found) begin
                        r_res_status <= ST_DONE;
                        r_res_idx    <= w_fit.index;
                        r_res_off    <= (SIZE_W'(w_fit.index) << w_sh) + HDR_BYTES;
                    end else begin
                        r_res_status <= ST_NO_RUN;
                    end
                end
            end
            default: ;
        endcase
    end

    // occupancy map and reference counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
            for (int k = 0; k < MAP_BITS; k++) begin
                r_ref[k] <= '0;
            end
        end else if (r_state == S_EXEC) begin
            case (r_act)
                ACT_FREE: begin
                    if (w_rc != '0) begin
                        r_ref[r_hdl] <= w_rc - REF_W'(1);
                        if (w_rc == REF_W'(1)) r_map <= r_map & ~w_rel_mask;
                    end
                end
                ACT_GET: begin
                    if (w_rc != '0 && w_rc != REF_MAX) r_ref[r_hdl] <= w_rc + REF_W'(1);
                end
                ACT_CLEAR: begin
                    r_map <= '0;
                    for (int k = 0; k < MAP_BITS; k++) begin
                        r_ref[k] <= '0;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_SCAN && w_fit.found) begin
            r_map <= r_map | w_fit.mask;
            r_ref[w_fit.index] <= REF_W'(1);
        end
    end

    // run lengths: written on allocation only, read only behind a nonzero count
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_fit.found) begin
            r_run[w_fit.index] <= r_need[CNT_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_off    <= r_res_off;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.bucket_index   = r_out_idx;
    assign o_rsp.payload_offset = r_out_off;

    // ---------------- assertions ----------------
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_scan_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fit.done |-> r_state == S_SCAN)
        else $error("scanner finished outside the scan step");

    a_run_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fit.found |-> (r_map & w_fit.mask) == '0)
        else $error("allocated run overlaps used buckets");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> o_rsp.valid)
        else $error("finished request produced no response");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bucket pool allocator: directed, saturation and random traffic.
module tb;
    import bbpa_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 38;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  bucket_index;
        logic [SIZE_W-1:0] payload_offset;
    } t_rsp;

    // Mirror of the allocator state plus the queue of responses owed by the block.
    class pool_tracker;
        bit [MAP_BITS-1:0]   occ;
        bit [CNT_W-1:0]      run_len [MAP_BITS];
        bit [REF_W-1:0]      ref_cnt [MAP_BITS];
        bit [CFG_DATA_W-1:0] bkt_cnt;
        bit [LOG2_W-1:0]     size_log2;
        t_rsp                want_rsp [$];
        int                  n_checked;
        int                  n_err;
        int                  n_miss;

        function new();
            occ       = '0;
            bkt_cnt   = 6'd32;
            size_log2 = 4'd6;
            n_checked = 0;
            n_err     = 0;
            n_miss    = 0;
            foreach (ref_cnt[i]) begin
                ref_cnt[i] = '0;
                run_len[i] = '0;
            end
        endfunction

        function bit [MAP_BITS-1:0] run_bits(int unsigned len, int unsigned start);
            bit [63:0] m;
            m = ((64'd1 << len) - 64'd1) << start;
            return m[MAP_BITS-1:0];
        endfunction

        function void set_cfg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] val);
            if (idx == CFG_BUCKETS_IN_USE) begin
                bkt_cnt = val;
            end else begin
                size_log2 = val[LOG2_W-1:0];
            end
        endfunction

        // Work out the response to one accepted request and update the mirror.
        function void take_req(t_action act, bit [SIZE_W-1:0] sz, bit [IDX_W-1:0] h);
            t_rsp            r;
            int unsigned     sh;
            int unsigned     n;
            bit [63:0]       bsz;
            bit [63:0]       rest;
            bit [63:0]       need;
            bit [63:0]       off;
            bit [MAP_BITS-1:0] m;
            bit              found;
            r.status         = ST_DONE;
            r.bucket_index   = '0;
            r.payload_offset = '0;
            case (act)
                ACT_ALLOC: begin
                    sh    = (size_log2 < MIN_LOG2) ? MIN_LOG2 : size_log2;
                    bsz   = 64'd1 << sh;
                    need  = 64'd1;
                    n     = (bkt_cnt > MNG_MAX) ? MNG_MAX : bkt_cnt;
                    found = 1'b0;
                    if (sz > bsz - HDR_BYTES) begin
                        rest = sz - (bsz - HDR_BYTES);
                        need = need + (rest >> sh);
                        if ((rest & (bsz - 64'd1)) != 0) need = need + 64'd1;
                    end
                    r.status = ST_NO_RUN;
                    if (need <= n) begin
                        for (int unsigned i = 0; i + need <= n && !found; i++) begin
                            m = run_bits(32'(need), i);
                            if ((occ & m) == '0) begin
                                found            = 1'b1;
                                occ              = occ | m;
                                run_len[i]       = CNT_W'(need);
                                ref_cnt[i]       = REF_W'(1);
                                off              = (64'(i) << sh) + HDR_BYTES;
                                r.status         = ST_DONE;
                                r.bucket_index   = IDX_W'(i);
                                r.payload_offset = off[SIZE_W-1:0];
                            end
                        end
                    end
                    if (!found) n_miss++;
                end
                ACT_FREE: begin
                    if (ref_cnt[h] == 0) begin
                        r.status = ST_BAD_HDL;
                    end else begin
                        ref_cnt[h]--;
                        if (ref_cnt[h] == 0) occ = occ & ~run_bits(run_len[h], h);
                    end
                end
                ACT_GET: begin
                    if (ref_cnt[h] == 0) begin
                        r.status = ST_BAD_HDL;
                    end else if (ref_cnt[h] == REF_MAX) begin
                        r.status = ST_REF_SAT;
                    end else begin
                        ref_cnt[h]++;
                    end
                end
                default: begin
                    occ = '0;
                    foreach (ref_cnt[i]) ref_cnt[i] = '0;
                end
            endcase
            want_rsp.push_back(r);
        endfunction

        function void match_rsp(t_status st, logic [IDX_W-1:0] bi, logic [SIZE_W-1:0] po);
            t_rsp e;
            if (want_rsp.size() == 0) begin
                n_err++;
                $display("%0t: response beat with nothing outstanding, expected none, %s",
                         $time, "actual");
                $display("%0t:   status %0d index %0d offset %0d", $time, st, bi, po);
                return;
            end
            e = want_rsp.pop_front();
            n_checked++;
            if (st !== e.status) begin
                n_err++;
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
            end
            if (bi !== e.bucket_index) begin
                n_err++;
                $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                         $time, e.bucket_index, bi);
            end
            if (po !== e.payload_offset) begin
                n_err++;
                $display("%0t: payload_offset mismatch, expected %0d, actual %0d",
                         $time, e.payload_offset, po);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bbpa_req_if req_ch ();
    bbpa_rsp_if rsp_ch ();
    bbpa_cfg_if cfg_ch ();

    bitmap_bucket_pool_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    pool_tracker trk;
    int          snd_idle;
    int          rcv_idle;
    int          cycles;
    int          n_req;
    int          n_cfg;

    int unsigned ph_cnt [N_PHASES] = '{32, 32, 8, 1, 63, 0, 2, 33, 31};
    int unsigned ph_log [N_PHASES] = '{6, 3, 0, 15, 4, 5, 15, 2, 10};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            trk.match_rsp(rsp_ch.status, rsp_ch.bucket_index, rsp_ch.payload_offset);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, trk.want_rsp.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_req(input t_action act, input logic [SIZE_W-1:0] sz,
                            input logic [IDX_W-1:0] h);
        while ($urandom_range(0, 99) < snd_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.request_size <= sz;
        req_ch.handle_index <= h;
        do @(posedge i_clk); while (!req_ch.ready);
        trk.take_req(act, sz, h);
        n_req++;
    endtask

    // Hold the request side until every owed response has come back.
    task automatic wait_drain();
        if (trk.want_rsp.size() != 0) begin
            req_ch.valid <= 1'b0;
            while (trk.want_rsp.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input bit [CFG_DATA_W-1:0] cnt, input bit [LOG2_W-1:0] lg);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_BUCKETS_IN_USE;
        cfg_ch.data  <= cnt;
        do @(posedge i_clk); while (!cfg_ch.ready);
        trk.set_cfg(CFG_BUCKETS_IN_USE, cnt);
        cfg_ch.index <= CFG_BUCKET_SIZE_LOG2;
        cfg_ch.data  <= {2'b00, lg};
        do @(posedge i_clk); while (!cfg_ch.ready);
        trk.set_cfg(CFG_BUCKET_SIZE_LOG2, {2'b00, lg});
        cfg_ch.valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [IDX_W-1:0] pick_handle(bit live);
        int unsigned cand [$];
        for (int i = 0; i < MAP_BITS; i++)
            if (trk.ref_cnt[i] != 0) cand.push_back(i);
        if (!live || cand.size() == 0) return IDX_W'($urandom_range(0, MAP_BITS - 1));
        return IDX_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic rand_item();
        int        pick;
        int        sel;
        bit [63:0] bsz;
        bit [63:0] sz;
        t_action   act;
        logic [IDX_W-1:0] h;
        pick = $urandom_range(0, 99);
        bsz  = 64'd1 << ((trk.size_log2 < MIN_LOG2) ? MIN_LOG2 : trk.size_log2);
        sz   = $urandom_range(0, 20'hFFFFF);
        h    = pick_handle(1'b0);
        if (pick < 3) begin
            act = ACT_CLEAR;
        end else if (pick < 45) begin
            act = ACT_ALLOC;
            sel = $urandom_range(0, 9);
            if (sel == 1) begin
                sz = bsz - HDR_BYTES + $urandom_range(0, 1);
            end else if (sel == 2) begin
                sz = $urandom_range(2, MAP_BITS) * bsz - HDR_BYTES + $urandom_range(0, 1);
            end else if (sel > 2) begin
                sz = $urandom_range(0, 3 * bsz);
            end
            if (sz > 20'hFFFFF) sz = 20'hFFFFF;
        end else if (pick < 75) begin
            act = ACT_FREE;
            h   = pick_handle(1'b1);
        end else if (pick < 90) begin
            act = ACT_GET;
            h   = pick_handle(1'b1);
        end else begin
            act = ($urandom_range(0, 1) == 0) ? ACT_FREE : ACT_GET;
        end
        send_req(act, sz[SIZE_W-1:0], h);
    endtask

    initial begin
        trk                 = new();
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        cycles              = 0;
        n_req               = 0;
        n_cfg               = 0;
        snd_idle            = 35;
        rcv_idle            = 46;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_ALLOC;
        req_ch.request_size = '0;
        req_ch.handle_index = '0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_BUCKETS_IN_USE;
        cfg_ch.data         = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry is 32 buckets of 64 bytes
        send_req(ACT_FREE,  20'd5,       5'd0);
        send_req(ACT_GET,   20'd0,       5'd31);
        send_req(ACT_ALLOC, 20'd0,       5'd0);
        send_req(ACT_ALLOC, 20'd60,      5'd0);
        send_req(ACT_ALLOC, 20'd61,      5'd0);
        send_req(ACT_ALLOC, 20'hFFFFF,   5'd0);
        send_req(ACT_GET,   20'd0,       5'd0);
        send_req(ACT_FREE,  20'd0,       5'd0);
        send_req(ACT_FREE,  20'd0,       5'd0);
        send_req(ACT_ALLOC, 20'd124,     5'd0);
        send_req(ACT_ALLOC, 20'd2044,    5'd0);
        send_req(ACT_CLEAR, 20'hFFFFF,   5'd31);
        send_req(ACT_ALLOC, 20'd2044,    5'd0);
        send_req(ACT_ALLOC, 20'd0,       5'd0);
        send_req(ACT_FREE,  20'd0,       5'd5);
        send_req(ACT_FREE,  20'd0,       5'd0);
        send_req(ACT_ALLOC, 20'd1980,    5'd0);
        send_req(ACT_ALLOC, 20'd0,       5'd0);  // last start position
        send_req(ACT_FREE,  20'd0,       5'd31);
        send_req(ACT_CLEAR, 20'd0,       5'd0);

        // reference count runs into its ceiling
        send_req(ACT_ALLOC, 20'd10, 5'd0);
        repeat (256) send_req(ACT_GET, SIZE_W'($urandom_range(0, 20'hFFFFF)), 5'd0);
        send_req(ACT_FREE,  20'd0, 5'd0);
        send_req(ACT_GET,   20'd0, 5'd0);
        send_req(ACT_GET,   20'd0, 5'd0);
        send_req(ACT_CLEAR, 20'd0, 5'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drain();
            if (p == 3) begin
                snd_idle = 46;
                rcv_idle = 35;
            end else if (p == 6) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_cfg(CFG_DATA_W'(ph_cnt[p]), LOG2_W'(ph_log[p]));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 2) wait_drain();
                rand_item();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d requests over %0d pool geometries, %0d responses compared,",
                 n_req, n_cfg, trk.n_checked);
        $display("%0d allocs refused for lack of a free run", trk.n_miss);
        if (trk.n_err == 0 && trk.want_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d responses missing", trk.n_err, trk.want_rsp.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
